// ----- design/tcrr_pkg.sv -----
package tcrr_pkg;

    localparam int LOGICAL_WIDTH  = 160;
    localparam int LOGICAL_HEIGHT = 128;
    localparam int CELL_W         = 6;
    localparam int CELL_H         = 8;
    localparam int GLYPH_W        = 5;
    localparam int GLYPH_H        = 7;
    localparam int NUM_COLS       = LOGICAL_WIDTH / CELL_W;
    localparam int NUM_ROWS       = LOGICAL_HEIGHT / CELL_H;
    localparam int COL_W          = $clog2(NUM_COLS + 1);
    localparam int ROW_W          = $clog2(NUM_ROWS + 1);
    localparam int ADDR_W         = 15;
    localparam int DATA_W         = 16;
    localparam int CODE_W         = 8;
    localparam int GLYPH_COUNT    = 96;
    localparam int GLYPH_IDX_W    = $clog2(GLYPH_COUNT);
    localparam int CFG_IDX_W      = 2;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    localparam logic OP_CHAR  = 1'b0;
    localparam logic OP_FRAME = 1'b1;

    localparam logic [CODE_W-1:0] CHAR_NUL      = 8'd0;
    localparam logic [CODE_W-1:0] CHAR_NEWLINE  = 8'd10;
    localparam logic [CODE_W-1:0] CHAR_RETURN   = 8'd13;
    localparam logic [CODE_W-1:0] CHAR_FIRST    = 8'd32;
    localparam logic [CODE_W-1:0] CHAR_LAST     = 8'd127;
    localparam logic [CODE_W-1:0] CHAR_QUESTION = 8'd63;

    localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SWAP       = 2'd2;

    localparam logic [DATA_W-1:0] FOREGROUND_RESET = 16'hFFFF;
    localparam logic [DATA_W-1:0] BACKGROUND_RESET = 16'h0000;

    typedef struct packed {
        logic [GLYPH_IDX_W-1:0] glyph;
        logic [ADDR_W-1:0]      base;
    } job_t;

    typedef struct packed {
        logic [DATA_W-1:0] foreground;
        logic [DATA_W-1:0] background;
        logic              swap;
    } cfg_t;

    // first column in the top byte
    localparam logic [39:0] FONT_ROM [GLYPH_COUNT] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
        40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
        40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
        40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
        40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
        40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h081454543C,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
        40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
        40'h00007F0000, 40'h0041360800, 40'h1008081008, 40'h0000000000
    };

    function automatic logic [7:0] font_column(input logic [GLYPH_IDX_W-1:0] glyph,
                                               input logic [2:0] dx);
        logic [39:0] entry;
        logic [7:0]  bits;
        entry = FONT_ROM[glyph];
        case (dx)
            3'd0:    bits = entry[39:32];
            3'd1:    bits = entry[31:24];
            3'd2:    bits = entry[23:16];
            3'd3:    bits = entry[15:8];
            3'd4:    bits = entry[7:0];
            default: bits = 8'h00;
        endcase
        return bits;
    endfunction

endpackage

// ----- design/tcrr_front.sv -----
module tcrr_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          operation,
    input  logic [tcrr_pkg::CODE_W-1:0]   char_code,
    input  logic                          queue_full,
    output logic                          push,
    output tcrr_pkg::job_t                push_job
);

    logic [tcrr_pkg::COL_W-1:0] col_reg, col_next;
    logic [tcrr_pkg::ROW_W-1:0] row_reg, row_next;
    logic                       ended_reg, ended_next;

    logic                       accept;
    logic                       wrap;
    logic [tcrr_pkg::COL_W-1:0] eff_col;
    logic [tcrr_pkg::ROW_W-1:0] eff_row;
    logic [tcrr_pkg::CODE_W-1:0] shown_code;
    logic [tcrr_pkg::CODE_W-1:0] glyph_full;

    assign in_stall = queue_full;
    assign accept   = in_valid && !in_stall;

    assign wrap    = (col_reg >= tcrr_pkg::COL_W'(tcrr_pkg::NUM_COLS));
    assign eff_col = wrap ? '0 : col_reg;
    assign eff_row = wrap ? row_reg + tcrr_pkg::ROW_W'(1) : row_reg;

    assign shown_code = (char_code < tcrr_pkg::CHAR_FIRST || char_code > tcrr_pkg::CHAR_LAST)
                        ? tcrr_pkg::CHAR_QUESTION : char_code;
    assign glyph_full = shown_code - tcrr_pkg::CHAR_FIRST;

    assign push_job.glyph = glyph_full[tcrr_pkg::GLYPH_IDX_W-1:0];
    // top-left pixel of the cell in rotated order
    assign push_job.base = tcrr_pkg::ADDR_W'(
        (tcrr_pkg::LOGICAL_WIDTH - 1 - tcrr_pkg::CELL_W * int'(eff_col))
        * tcrr_pkg::LOGICAL_HEIGHT + tcrr_pkg::CELL_H * int'(eff_row));

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        ended_next = ended_reg;
        push       = 1'b0;
        if (accept)
        begin
            if (operation == tcrr_pkg::OP_FRAME)
            begin
                col_next   = '0;
                row_next   = '0;
                ended_next = 1'b0;
            end
            else if (!ended_reg && row_reg < tcrr_pkg::ROW_W'(tcrr_pkg::NUM_ROWS))
            begin
                if (char_code == tcrr_pkg::CHAR_NUL)
                begin
                    ended_next = 1'b1;
                end
                else if (char_code == tcrr_pkg::CHAR_NEWLINE)
                begin
                    col_next = '0;
                    row_next = row_reg + tcrr_pkg::ROW_W'(1);
                end
                else if (char_code != tcrr_pkg::CHAR_RETURN)
                begin
                    row_next = eff_row;
                    if (eff_row < tcrr_pkg::ROW_W'(tcrr_pkg::NUM_ROWS))
                    begin
                        col_next = eff_col + tcrr_pkg::COL_W'(1);
                        push     = 1'b1;
                    end
                    else
                    begin
                        col_next = eff_col;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            ended_reg <= 1'b0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            ended_reg <= ended_next;
        end
    end

endmodule

// ----- design/tcrr_queue.sv -----
module tcrr_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tcrr_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output tcrr_pkg::job_t head
);

    tcrr_pkg::job_t              slot_reg [tcrr_pkg::QUEUE_DEPTH];
    logic [tcrr_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [tcrr_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [tcrr_pkg::QCNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == tcrr_pkg::QCNT_W'(tcrr_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + tcrr_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + tcrr_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + tcrr_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - tcrr_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("push into full queue");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("pop from empty queue");

endmodule

// ----- design/tcrr_back.sv -----
module tcrr_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tcrr_pkg::cfg_t               cfg,
    input  logic                         queue_empty,
    input  tcrr_pkg::job_t               queue_head,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [tcrr_pkg::ADDR_W-1:0]  pixel_address,
    output logic [tcrr_pkg::DATA_W-1:0]  pixel_data,
    output logic                         last_pixel
);

    logic                          active_reg, active_next;
    tcrr_pkg::job_t                job_reg, job_next;
    logic [2:0]                    dx_reg, dx_next;
    logic [2:0]                    dy_reg, dy_next;
    logic                          phase_reg, phase_next;
    logic                          valid_reg, valid_next;
    logic [tcrr_pkg::ADDR_W-1:0]   addr_reg;
    logic [tcrr_pkg::DATA_W-1:0]   data_reg;
    logic                          last_reg;

    logic                          fire;
    logic                          is_last;
    logic [7:0]                    column_bits;
    logic                          set_pixel;
    logic [tcrr_pkg::DATA_W-1:0]   color;
    logic [tcrr_pkg::DATA_W-1:0]   word;
    logic [tcrr_pkg::ADDR_W-1:0]   addr;

    assign fire    = active_reg && (!valid_reg || !out_stall);
    assign is_last = phase_reg && (dx_reg == 3'(tcrr_pkg::CELL_W - 1));
    assign pop     = !queue_empty && (!active_reg || (fire && is_last));

    assign column_bits = tcrr_pkg::font_column(job_reg.glyph, dx_reg);
    assign set_pixel   = !phase_reg && column_bits[dy_reg];
    assign color       = set_pixel ? cfg.foreground : cfg.background;
    assign word        = cfg.swap ? {color[7:0], color[15:8]} : color;
    assign addr        = job_reg.base
                         - tcrr_pkg::ADDR_W'(tcrr_pkg::LOGICAL_HEIGHT * int'(dx_reg))
                         + tcrr_pkg::ADDR_W'(dy_reg);

    // glyph columns then spacing column top to bottom, then bottom row
    always_comb
    begin
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        phase_next  = phase_reg;
        active_next = active_reg;
        job_next    = job_reg;
        valid_next  = valid_reg;
        if (valid_reg && !out_stall)
        begin
            valid_next = 1'b0;
        end
        if (fire)
        begin
            valid_next = 1'b1;
            if (!phase_reg)
            begin
                if (dy_reg == 3'(tcrr_pkg::GLYPH_H - 1))
                begin
                    if (dx_reg == 3'(tcrr_pkg::CELL_W - 1))
                    begin
                        phase_next = 1'b1;
                        dx_next    = '0;
                        dy_next    = 3'(tcrr_pkg::CELL_H - 1);
                    end
                    else
                    begin
                        dx_next = dx_reg + 3'd1;
                        dy_next = '0;
                    end
                end
                else
                begin
                    dy_next = dy_reg + 3'd1;
                end
            end
            else if (is_last)
            begin
                phase_next  = 1'b0;
                dx_next     = '0;
                dy_next     = '0;
                active_next = 1'b0;
            end
            else
            begin
                dx_next = dx_reg + 3'd1;
            end
        end
        if (pop)
        begin
            active_next = 1'b1;
            job_next    = queue_head;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            dx_reg     <= '0;
            dy_reg     <= '0;
            phase_reg  <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            phase_reg  <= phase_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        if (fire)
        begin
            addr_reg <= addr;
            data_reg <= word;
            last_reg <= is_last;
        end
    end

    assign out_valid     = valid_reg;
    assign pixel_address = addr_reg;
    assign pixel_data    = data_reg;
    assign last_pixel    = last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (dx_reg == '0 && dy_reg == '0 && !phase_reg))
        else $error("pixel counters not idle without a job");
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> dy_reg == 3'(tcrr_pkg::CELL_H - 1))
        else $error("bottom row phase off the bottom row");
    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg && !phase_reg |-> dy_reg < 3'(tcrr_pkg::GLYPH_H))
        else $error("column scan past glyph height");

endmodule

// ----- design/text_cell_rasterizer_rotated_unit.sv -----
// Text cell rasterizer: a character word stream is laid out on a page of 26 x 16 cells of
// 6x8 pixels, and each printable character comes out as 48 pixel words (glyph columns top to
// bottom, spacing column, bottom row) with addresses in the rotated panel order. A character
// that draws comes out one pixel word per cycle while out_stall is low, as set by the pixel
// sequencer; control characters, frame starts and dropped characters give no output. A
// four-entry job queue sits between the input classifier and the pixel
// sequencer, so while the sequencer draws one character up to four more may be taken ahead of
// the output. Color and byte-swap registers are read while pixels go out and should be written
// only when the unit is idle.
module text_cell_rasterizer_rotated_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            operation,
    input  logic [tcrr_pkg::CODE_W-1:0]     char_code,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [tcrr_pkg::ADDR_W-1:0]     pixel_address,
    output logic [tcrr_pkg::DATA_W-1:0]     pixel_data,
    output logic                            last_pixel,
    input  logic                            cfg_write_en,
    input  logic [tcrr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tcrr_pkg::DATA_W-1:0]     cfg_data
);

    tcrr_pkg::cfg_t  cfg_reg, cfg_next;
    logic            push;
    tcrr_pkg::job_t  push_job;
    logic            queue_full;
    logic            queue_empty;
    logic            pop;
    tcrr_pkg::job_t  queue_head;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                tcrr_pkg::REG_FOREGROUND: cfg_next.foreground = cfg_data;
                tcrr_pkg::REG_BACKGROUND: cfg_next.background = cfg_data;
                tcrr_pkg::REG_SWAP:       cfg_next.swap       = cfg_data[0];
                default:                  cfg_next            = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.foreground <= tcrr_pkg::FOREGROUND_RESET;
            cfg_reg.background <= tcrr_pkg::BACKGROUND_RESET;
            cfg_reg.swap       <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tcrr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .char_code  (char_code),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    tcrr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (queue_full),
        .pop      (pop),
        .empty    (queue_empty),
        .head     (queue_head)
    );

    tcrr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .queue_empty   (queue_empty),
        .queue_head    (queue_head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pixel_address (pixel_address),
        .pixel_data    (pixel_data),
        .last_pixel    (last_pixel)
    );

endmodule

// ----- test/text_cell_rasterizer_rotated_unit_tb.sv -----
module text_cell_rasterizer_rotated_unit_tb;

    localparam int PANEL_W     = 160;
    localparam int PANEL_H     = 128;
    localparam int PAGE_COLS   = PANEL_W / 6;
    localparam int PAGE_ROWS   = PANEL_H / 8;
    localparam int CYCLE_LIMIT = 1000000;

    // five glyph columns per entry, first column in the top byte, bit 0 is the top row
    localparam logic [39:0] FONT_COLUMNS [96] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
        40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
        40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
        40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
        40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
        40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h081454543C,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
        40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
        40'h00007F0000, 40'h0041360800, 40'h1008081008, 40'h0000000000
    };

    typedef struct {
        logic [tcrr_pkg::ADDR_W-1:0] addr;
        logic [tcrr_pkg::DATA_W-1:0] data;
        logic                        last;
    } pixel_word_t;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    logic                           operation;
    logic [tcrr_pkg::CODE_W-1:0]    char_code;
    logic                           out_valid;
    logic                           out_stall;
    logic [tcrr_pkg::ADDR_W-1:0]    pixel_address;
    logic [tcrr_pkg::DATA_W-1:0]    pixel_data;
    logic                           last_pixel;
    logic                           cfg_write_en;
    logic [tcrr_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [tcrr_pkg::DATA_W-1:0]    cfg_data;

    pixel_word_t expected_pixels[$];

    logic [tcrr_pkg::DATA_W-1:0] fg_color;
    logic [tcrr_pkg::DATA_W-1:0] bg_color;
    bit                          swap_on;
    int                          cur_col;
    int                          cur_row;
    bit                          text_done;

    bit tx_idle;
    bit rx_idle;
    int hold_cycles;

    int mismatches;
    int words_sent;
    int words_counted;
    int frames_seen;
    int line_wraps;
    int words_dropped;
    int pixels_checked;
    int cycle_count;

    text_cell_rasterizer_rotated_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .char_code     (char_code),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pixel_address (pixel_address),
        .pixel_data    (pixel_data),
        .last_pixel    (last_pixel),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d pixel words outstanding", $time,
                     expected_pixels.size());
            $display("text_cell_rasterizer_rotated_unit test failed");
            $finish;
        end
    end

    function automatic void push_pixel(input int x, input int y,
                                       input logic [tcrr_pkg::DATA_W-1:0] color,
                                       input bit last);
        pixel_word_t w;
        int unsigned a;
        a = (PANEL_W - 1 - x) * PANEL_H + y;
        w.addr = a[tcrr_pkg::ADDR_W-1:0];
        w.data = swap_on ? {color[7:0], color[15:8]} : color;
        w.last = last;
        expected_pixels.push_back(w);
    endfunction

    // returns 1 when the word changes state or draws
    function automatic bit predict_word(input logic op, input logic [tcrr_pkg::CODE_W-1:0] code);
        int cx;
        int cy;
        int c;
        int r;
        int g;
        logic [39:0] entry;
        logic [7:0]  bits;
        logic [7:0]  shown;
        if (op == tcrr_pkg::OP_FRAME)
        begin
            cur_col   = 0;
            cur_row   = 0;
            text_done = 1'b0;
            frames_seen++;
            return 1'b1;
        end
        if (text_done || cur_row >= PAGE_ROWS)
        begin
            words_dropped++;
            return 1'b0;
        end
        if (code == tcrr_pkg::CHAR_NUL)
        begin
            text_done = 1'b1;
            return 1'b1;
        end
        if (code == tcrr_pkg::CHAR_RETURN)
            return 1'b0;
        if (code == tcrr_pkg::CHAR_NEWLINE)
        begin
            cur_col = 0;
            cur_row++;
            return 1'b1;
        end
        if (cur_col >= PAGE_COLS)
        begin
            cur_col = 0;
            cur_row++;
            line_wraps++;
            if (cur_row >= PAGE_ROWS)
                return 1'b1;
        end
        shown = (code < tcrr_pkg::CHAR_FIRST || code > tcrr_pkg::CHAR_LAST)
                ? tcrr_pkg::CHAR_QUESTION : code;
        g     = int'(shown) - int'(tcrr_pkg::CHAR_FIRST);
        entry = FONT_COLUMNS[g];
        cx    = cur_col * 6;
        cy    = cur_row * 8;
        for (c = 0; c < 5; c++)
        begin
            bits = 8'(entry >> (8 * (4 - c)));
            for (r = 0; r < 7; r++)
                push_pixel(cx + c, cy + r, bits[r] ? fg_color : bg_color, 1'b0);
        end
        for (r = 0; r < 7; r++)
            push_pixel(cx + 5, cy + r, bg_color, 1'b0);
        for (c = 0; c < 6; c++)
            push_pixel(cx + c, cy + 7, bg_color, c == 5);
        cur_col++;
        return 1'b1;
    endfunction

    always @(posedge clk)
    begin : check_pixels
        pixel_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            pixels_checked++;
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected pixel word, expected none, %s %h data %h last %b",
                         $time, "got address", pixel_address, pixel_data, last_pixel);
                mismatches++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (pixel_address !== want.addr)
                begin
                    $display("%0t: pixel_address mismatch, expected %h, got %h", $time,
                             want.addr, pixel_address);
                    mismatches++;
                end
                if (pixel_data !== want.data)
                begin
                    $display("%0t: pixel_data mismatch, expected %h, got %h", $time,
                             want.data, pixel_data);
                    mismatches++;
                end
                if (last_pixel !== want.last)
                begin
                    $display("%0t: last_pixel mismatch, expected %b, got %b", $time,
                             want.last, last_pixel);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : pixel_receiver
        int n;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                n           = hold_cycles;
                hold_cycles = 0;
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (out_valid && !out_stall)
            begin
                n = rx_idle ? $urandom_range(0, 10) : 0;
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    task automatic send_word(input logic op, input logic [tcrr_pkg::CODE_W-1:0] code);
        int gap;
        gap = tx_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        char_code <= code;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
        if (predict_word(op, code))
            words_counted++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_config(input logic [tcrr_pkg::CFG_IDX_W-1:0] idx,
                                input logic [tcrr_pkg::DATA_W-1:0] value);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
        case (idx)
            tcrr_pkg::REG_FOREGROUND: fg_color = value;
            tcrr_pkg::REG_BACKGROUND: bg_color = value;
            tcrr_pkg::REG_SWAP:       swap_on  = value[0];
            default:                  ;
        endcase
    endtask

    task automatic test_glyph_extremes();
        send_word(tcrr_pkg::OP_FRAME, 8'hFF);
        send_word(tcrr_pkg::OP_CHAR, 8'd65);
        send_word(tcrr_pkg::OP_CHAR, tcrr_pkg::CHAR_FIRST);
        send_word(tcrr_pkg::OP_CHAR, 8'd126);
        send_word(tcrr_pkg::OP_CHAR, tcrr_pkg::CHAR_LAST);
        send_word(tcrr_pkg::OP_CHAR, 8'd128);
        send_word(tcrr_pkg::OP_CHAR, 8'd255);
        send_word(tcrr_pkg::OP_CHAR, 8'd1);
        send_word(tcrr_pkg::OP_CHAR, 8'd31);
    endtask

    task automatic test_control_codes();
        send_word(tcrr_pkg::OP_CHAR, tcrr_pkg::CHAR_RETURN);
        send_word(tcrr_pkg::OP_CHAR, tcrr_pkg::CHAR_NEWLINE);
        send_word(tcrr_pkg::OP_CHAR, 8'd72);
        send_word(tcrr_pkg::OP_CHAR, tcrr_pkg::CHAR_NUL);
        send_word(tcrr_pkg::OP_CHAR, 8'd105);
        send_word(tcrr_pkg::OP_CHAR, tcrr_pkg::CHAR_NEWLINE);
        send_word(tcrr_pkg::OP_FRAME, 8'h00);
        send_word(tcrr_pkg::OP_CHAR, 8'd106);
    endtask

    task automatic test_color_registers();
        wait_idle();
        write_config(tcrr_pkg::REG_FOREGROUND, 16'h1234);
        write_config(tcrr_pkg::REG_BACKGROUND, 16'hABCD);
        write_config(tcrr_pkg::REG_SWAP, 16'h0001);
        send_word(tcrr_pkg::OP_CHAR, 8'd87);
        wait_idle();
        write_config(tcrr_pkg::REG_FOREGROUND, 16'h0000);
        write_config(tcrr_pkg::REG_BACKGROUND, 16'hFFFF);
        write_config(tcrr_pkg::REG_SWAP, 16'hFFFE);
        send_word(tcrr_pkg::OP_CHAR, 8'd77);
        wait_idle();
    endtask

    task automatic test_backpressure();
        int i;
        tx_idle     = 1'b0;
        rx_idle     = 1'b0;
        hold_cycles = 400;
        for (i = 0; i < 12; i++)
            send_word(tcrr_pkg::OP_CHAR, 8'd48 + i[7:0]);
        wait_idle();
    endtask

    task automatic test_random_stream();
        int phase;
        int r;
        int n;
        int i;
        int target;
        logic [tcrr_pkg::CODE_W-1:0] code;
        for (phase = 0; phase < 4; phase++)
        begin
            wait_idle();
            case (phase)
                0:
                begin
                    write_config(tcrr_pkg::REG_FOREGROUND, 16'h0000);
                    write_config(tcrr_pkg::REG_BACKGROUND, 16'hFFFF);
                    write_config(tcrr_pkg::REG_SWAP, 16'h0001);
                end
                2:
                begin
                    write_config(tcrr_pkg::REG_FOREGROUND, 16'hFFFF);
                    write_config(tcrr_pkg::REG_BACKGROUND, 16'h0000);
                    write_config(tcrr_pkg::REG_SWAP, 16'h0000);
                end
                default:
                begin
                    write_config(tcrr_pkg::REG_FOREGROUND,
                                 tcrr_pkg::DATA_W'($urandom_range(0, 65535)));
                    write_config(tcrr_pkg::REG_BACKGROUND,
                                 tcrr_pkg::DATA_W'($urandom_range(0, 65535)));
                    write_config(tcrr_pkg::REG_SWAP,
                                 tcrr_pkg::DATA_W'($urandom_range(0, 65535)));
                end
            endcase
            tx_idle = (phase != 1);
            rx_idle = (phase != 1);
            send_word(tcrr_pkg::OP_FRAME, tcrr_pkg::CODE_W'($urandom_range(0, 255)));
            target = words_sent + 40;
            while (words_sent < target)
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                    send_word(tcrr_pkg::OP_CHAR, tcrr_pkg::CODE_W'($urandom_range(32, 127)));
                else if (r < 64)
                    send_word(tcrr_pkg::OP_CHAR, tcrr_pkg::CHAR_NEWLINE);
                else if (r < 67)
                    send_word(tcrr_pkg::OP_CHAR, tcrr_pkg::CHAR_RETURN);
                else if (r < 72)
                begin
                    if ($urandom_range(0, 1))
                        code = tcrr_pkg::CODE_W'($urandom_range(128, 255));
                    else
                    begin
                        code = tcrr_pkg::CODE_W'($urandom_range(1, 31));
                        while (code == tcrr_pkg::CHAR_NEWLINE || code == tcrr_pkg::CHAR_RETURN)
                            code = tcrr_pkg::CODE_W'($urandom_range(1, 31));
                    end
                    send_word(tcrr_pkg::OP_CHAR, code);
                end
                else if (r < 74)
                    send_word(tcrr_pkg::OP_CHAR, tcrr_pkg::CHAR_NUL);
                else if (r < 77)
                    send_word(tcrr_pkg::OP_FRAME, tcrr_pkg::CODE_W'($urandom_range(0, 255)));
                else if (r < 80)
                begin
                    // a run long enough to wrap the line
                    n = $urandom_range(26, 32);
                    for (i = 0; i < n; i++)
                        send_word(tcrr_pkg::OP_CHAR,
                                  tcrr_pkg::CODE_W'($urandom_range(32, 127)));
                end
                else if (r < 82)
                begin
                    n = $urandom_range(4, 16);
                    for (i = 0; i < n; i++)
                        send_word(tcrr_pkg::OP_CHAR, tcrr_pkg::CHAR_NEWLINE);
                end
                else
                    send_word(tcrr_pkg::OP_CHAR, tcrr_pkg::CODE_W'($urandom_range(0, 255)));
            end
        end
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        operation    <= tcrr_pkg::OP_CHAR;
        char_code    <= '0;
        cfg_write_en <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        fg_color     = tcrr_pkg::FOREGROUND_RESET;
        bg_color     = tcrr_pkg::BACKGROUND_RESET;
        swap_on      = 1'b0;
        cur_col      = 0;
        cur_row      = 0;
        text_done    = 1'b0;
        tx_idle      = 1'b1;
        rx_idle      = 1'b1;
        hold_cycles  = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_glyph_extremes();
        test_control_codes();
        test_color_registers();
        test_backpressure();
        test_random_stream();

        wait_idle();
        repeat (64) @(posedge clk);
        $display("run covered %0d input words (%0d drew or moved the cursor), %0d frame starts",
                 words_sent, words_counted, frames_seen);
        $display("%0d line wraps, %0d pixel words checked, %0d words dropped after end or full page",
                 line_wraps, pixels_checked, words_dropped);
        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("text_cell_rasterizer_rotated_unit test passed");
        else
            $display("text_cell_rasterizer_rotated_unit test failed");
        $finish;
    end

endmodule
